// ----- hdl/cte_pkg.sv -----
// ----------------------------------------------------------------------------
// cte_pkg: shared types and constants of the capability table engine
// Request codes, entry layout and the reset values of the root capability.
// ----------------------------------------------------------------------------
package cte_pkg;

  localparam logic [1:0] REQ_DERIVE = 2'd0;
  localparam logic [1:0] REQ_REVOKE = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [7:0]  NO_OWNER    = 8'hFF;
  localparam logic [6:0]  ROOT_FUEL   = 7'd64;
  localparam logic [31:0] ROOT_BASE   = 32'h8000_0000;
  localparam logic [31:0] ROOT_SIZE   = 32'h0001_0000;
  localparam logic [2:0]  ROOT_RIGHTS = 3'h7;

  // entry fields other than the owner; the owner lives in its own memory
  typedef struct packed {
    logic [6:0]  fuel_left;
    logic [6:0]  fuel_max;
    logic [31:0] base;
    logic [31:0] size;
    logic [2:0]  rights;
  } cap_t;

  localparam int CAP_W = $bits(cap_t);

endpackage

// ----- hdl/cte_ram.sv -----
// ----------------------------------------------------------------------------
// cte_ram: generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/capability_table_engine.sv -----
// ----------------------------------------------------------------------------
// capability_table_engine: table of memory capabilities
// Derive, revoke and delete requests on a table of owned, fueled regions.
// ----------------------------------------------------------------------------
// Usage:
// Requests come in on the in_* channel (in_valid / in_stall), one result per
// request leaves on the out_* channel (out_valid / out_stall). A transfer
// happens on a clock edge with valid high and stall low.
// One request is worked on at a time; in_stall is high while it is in flight.
// A request is read from the table, then checked; a granted derive then writes
// the child entry, and a revoke walks the child slots at offsets fuel_left up to
// fuel_max - 1 from the parent, marking them unowned, and refills the parent's
// fuel. The engine goes back to idle when a result is loaded.
// The result sits in an output register, so a stalled receiver holds the
// result while the next request is already taken and worked on; that request
// waits before its result stage until the register is free.
// Reset (rst, synchronous) starts a clearing pass over all TABLE_DEPTH entries
// that writes the reset entries; in_stall is high during the pass.
// ----------------------------------------------------------------------------
module capability_table_engine #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [6:0]  requester,
  input  logic [5:0]  entry_index,
  input  logic [6:0]  child_fuel,
  input  logic [31:0] child_base,
  input  logic [31:0] child_size,
  input  logic [2:0]  child_rights,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [5:0]  result_index
);

  import cte_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DWR  = 3'd4;
  localparam logic [2:0] S_REV  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] clr_cnt;

  // latched request
  logic [1:0]  r_req;
  logic [6:0]  r_pid;
  logic [5:0]  r_idx;
  logic [6:0]  r_fuel;
  logic [31:0] r_base;
  logic [31:0] r_size;
  logic [2:0]  r_rwx;
  logic        r_bad;

  // latched parent entry and check results
  logic [7:0]  p_owner;
  cap_t        p_cap;
  logic        own_ok;
  logic        fuel_ok;
  logic        rights_ok;
  logic        base_ok;
  logic [6:0]  remain;
  logic [32:0] sum_child;
  logic [32:0] sum_parent;

  logic [7:0] j_idx;
  logic [6:0] k;
  logic       res_status;
  logic [5:0] res_idx;

  // memory ports
  logic          own_we;
  logic [AW-1:0] own_wa;
  logic [7:0]    own_wd;
  logic [7:0]    own_rd;
  logic          cap_we;
  logic [AW-1:0] cap_wa;
  cap_t          cap_wd;
  cap_t          cap_rd;
  logic [AW-1:0] rd_addr;

  logic       in_fire;
  logic       out_free;
  logic [7:0] j_calc;
  logic       j_ok;
  logic       bound_ok;
  logic       err;
  logic [7:0] rv_slot;
  logic       rv_ok;
  logic       rv_more;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign rd_addr  = AW'(entry_index);

  assign j_calc   = {2'b00, r_idx} + {1'b0, remain};
  assign j_ok     = {24'd0, j_calc} < 32'(TABLE_DEPTH);
  assign bound_ok = sum_child <= sum_parent;
  assign err = r_bad || !own_ok ||
               ((r_req == REQ_DERIVE) &&
                (!fuel_ok || !base_ok || !bound_ok || !rights_ok || !j_ok));

  assign rv_slot = {2'b00, r_idx} + {1'b0, k};
  assign rv_ok   = {24'd0, rv_slot} < 32'(TABLE_DEPTH);
  assign rv_more = k < p_cap.fuel_max;

  cte_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_owner_ram (
    .clk     (clk),
    .we      (own_we),
    .wr_addr (own_wa),
    .wr_data (own_wd),
    .rd_addr (rd_addr),
    .rd_data (own_rd)
  );

  cte_ram #(.WIDTH(CAP_W), .DEPTH(TABLE_DEPTH)) u_cap_ram (
    .clk     (clk),
    .we      (cap_we),
    .wr_addr (cap_wa),
    .wr_data (cap_wd),
    .rd_addr (rd_addr),
    .rd_data (cap_rd)
  );

  always_comb begin
    own_we = 1'b0;
    own_wa = AW'(r_idx);
    own_wd = NO_OWNER;
    cap_we = 1'b0;
    cap_wa = AW'(r_idx);
    cap_wd = p_cap;
    case (state)
      S_CLR: begin
        own_we = 1'b1;
        own_wa = clr_cnt;
        own_wd = 8'd0;
        cap_we = 1'b1;
        cap_wa = clr_cnt;
        if (clr_cnt == '0) begin
          cap_wd = '{fuel_left: ROOT_FUEL, fuel_max: ROOT_FUEL, base: ROOT_BASE,
                     size: ROOT_SIZE, rights: ROOT_RIGHTS};
        end else begin
          cap_wd = '0;
        end
      end
      S_EVAL: begin
        if (!err && r_req == REQ_DERIVE) begin
          cap_we           = 1'b1;
          cap_wd.fuel_left = remain;
        end
        if (!err && r_req == REQ_DELETE) begin
          own_we = 1'b1;
        end
      end
      S_DWR: begin
        own_we = 1'b1;
        own_wa = AW'(32'(j_idx));
        own_wd = p_owner;
        cap_we = 1'b1;
        cap_wa = AW'(32'(j_idx));
        cap_wd = '{fuel_left: r_fuel, fuel_max: r_fuel, base: r_base,
                   size: r_size, rights: r_rwx};
      end
      S_REV: begin
        if (rv_more) begin
          own_we = rv_ok;
          own_wa = AW'(32'(rv_slot));
        end else begin
          cap_we           = 1'b1;
          cap_wd.fuel_left = p_cap.fuel_max;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            r_req  <= req_type;
            r_pid  <= requester;
            r_idx  <= entry_index;
            r_fuel <= child_fuel;
            r_base <= child_base;
            r_size <= child_size;
            r_rwx  <= child_rights;
            r_bad  <= (req_type > REQ_DELETE) ||
                      ({26'd0, entry_index} >= 32'(TABLE_DEPTH));
            state  <= S_READ;
          end
        end
        S_READ: begin
          p_owner    <= own_rd;
          p_cap      <= cap_rd;
          own_ok     <= own_rd == {1'b0, r_pid};
          fuel_ok    <= (r_fuel != 7'd0) && (cap_rd.fuel_left >= r_fuel);
          rights_ok  <= (cap_rd.rights & r_rwx) == r_rwx;
          base_ok    <= r_base >= cap_rd.base;
          remain     <= cap_rd.fuel_left - r_fuel;
          sum_child  <= {1'b0, r_base} + {1'b0, r_size};
          sum_parent <= {1'b0, cap_rd.base} + {1'b0, cap_rd.size};
          state      <= S_EVAL;
        end
        S_EVAL: begin
          j_idx <= j_calc;
          k     <= p_cap.fuel_left;
          if (err) begin
            res_status <= 1'b1;
            res_idx    <= 6'd0;
            state      <= S_RESP;
          end else begin
            res_status <= 1'b0;
            case (r_req)
              REQ_DERIVE: begin
                res_idx <= j_calc[5:0];
                state   <= S_DWR;
              end
              REQ_REVOKE: begin
                res_idx <= r_idx;
                state   <= S_REV;
              end
              default: begin
                res_idx <= r_idx;
                state   <= S_RESP;
              end
            endcase
          end
        end
        S_DWR: begin
          state <= S_RESP;
        end
        S_REV: begin
          if (rv_more) begin
            k <= k + 7'd1;
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            result_index <= res_idx;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_stall)
    else $error("request taken while another is in flight");

  a_err_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (result_index == 6'd0))
    else $error("rejected request carries a nonzero index");

  a_child_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWR) |-> ({24'd0, j_idx} < 32'(TABLE_DEPTH)))
    else $error("child write outside the table");
`endif

endmodule
